### rtl/gwds_pkg.sv
// ----------------------------------------------------------------------------
// gwds_pkg
// Shared types, constants and helpers for the Gaussian-weighted derivative
// stencil unit.
// ----------------------------------------------------------------------------
package gwds_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam int EXP_BITS = 21;

    localparam logic [62:0] T_LIMIT  = 63'd1509022;
    localparam logic [62:0] T_CAP    = 63'd1509023;
    localparam logic [62:0] CAP_F    = 63'h0000_0000_8000_0000;
    localparam logic [62:0] CAP_STEP = 63'h4000_0000_0000_0000;

    localparam logic [5:0] FB_T    = 6'd15;
    localparam logic [5:0] FB_FULL = 6'd32;
    localparam logic [5:0] FB_HALF = 6'd16;
    localparam logic [5:0] FB_NONE = 6'd0;

    typedef enum logic [2:0] {
        REG_SIGMA    = 3'd0,
        REG_KIND     = 3'd1,
        REG_WRAP_X   = 3'd2,
        REG_WRAP_Y   = 3'd3,
        REG_WRAP_Z   = 3'd4,
        REG_PERIOD_X = 3'd5,
        REG_PERIOD_Y = 3'd6,
        REG_PERIOD_Z = 3'd7
    } cfg_idx_t;

    localparam logic [3:0] KIND_VALUE = 4'd0;
    localparam logic [3:0] KIND_X     = 4'd1;
    localparam logic [3:0] KIND_Y     = 4'd2;
    localparam logic [3:0] KIND_Z     = 4'd3;
    localparam logic [3:0] KIND_XX    = 4'd4;
    localparam logic [3:0] KIND_YY    = 4'd5;
    localparam logic [3:0] KIND_ZZ    = 4'd6;
    localparam logic [3:0] KIND_XY    = 4'd7;
    localparam logic [3:0] KIND_XZ    = 4'd8;
    localparam logic [3:0] KIND_YZ    = 4'd9;

    typedef logic signed [31:0] q16_t;

    typedef struct packed {
        q16_t dx;
        q16_t dy;
        q16_t dz;
        q16_t val;
        logic last;
    } item_t;

    typedef struct packed {
        logic [31:0] sigma;
        logic [3:0]  deriv_kind;
    } cfg_back_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
        logic [5:0]  fb;
        logic [62:0] cap;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [62:0] quo;
    } div_rsp_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? (32'd0 - 32'(v)) : 32'(v);
        return r;
    endfunction

    function automatic logic [31:0] sat_mag(input logic [63:0] m, input logic neg);
        logic [31:0] r;
        if (neg)
            r = (m > 64'h8000_0000) ? 32'h8000_0000 : m[31:0];
        else
            r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        return r;
    endfunction

    function automatic logic [31:0] exp_coef(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'd4294901760;
            5'd1:    r = 32'd4294836226;
            5'd2:    r = 32'd4294705160;
            5'd3:    r = 32'd4294443040;
            5'd4:    r = 32'd4293918848;
            5'd5:    r = 32'd4292870656;
            5'd6:    r = 32'd4290775039;
            5'd7:    r = 32'd4286586875;
            5'd8:    r = 32'd4278222805;
            5'd9:    r = 32'd4261543595;
            5'd10:   r = 32'd4228380000;
            5'd11:   r = 32'd4162825044;
            5'd12:   r = 32'd4034748382;
            5'd13:   r = 32'd3790295335;
            5'd14:   r = 32'd3344923893;
            5'd15:   r = 32'd2605029347;
            5'd16:   r = 32'd1580030169;
            5'd17:   r = 32'd581260615;
            5'd18:   r = 32'd78665070;
            5'd19:   r = 32'd1440801;
            5'd20:   r = 32'd483;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/gwds_front.sv
// ----------------------------------------------------------------------------
// gwds_front
// Configuration registers, input beat acceptance and periodic folding of the
// offsets ahead of the item queue.
// ----------------------------------------------------------------------------
module gwds_front
    import gwds_pkg::*;
#(
    parameter int AXES = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  q16_t        offset_x,
    input  q16_t        offset_y,
    input  q16_t        offset_z,
    input  q16_t        sample_value,
    input  logic        last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        q_full,
    output logic        q_wr,
    output item_t       q_item,
    output cfg_back_t   cfg_back
);

    logic [31:0] sigma_reg;
    logic [3:0]  kind_reg;
    logic [30:0] wrap_x_reg;
    logic [30:0] wrap_y_reg;
    logic [30:0] wrap_z_reg;
    logic [30:0] per_x_reg;
    logic [30:0] per_y_reg;
    logic [30:0] per_z_reg;

    function automatic q16_t fold(input q16_t v, input logic [30:0] wd,
                                  input logic [30:0] per);
        logic signed [33:0] x;
        logic signed [33:0] w;
        logic signed [33:0] p;
        q16_t r;
        x = 34'(v);
        w = $signed({3'b000, wd});
        p = $signed({3'b000, per});
        if (x > w)
            x = x - p;
        else if (x < -w)
            x = x + p;
        if (x > 34'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (x < -34'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg  <= 32'd65536;
            kind_reg   <= KIND_VALUE;
            wrap_x_reg <= 31'h7FFF_FFFF;
            wrap_y_reg <= 31'h7FFF_FFFF;
            wrap_z_reg <= 31'h7FFF_FFFF;
            per_x_reg  <= 31'd0;
            per_y_reg  <= 31'd0;
            per_z_reg  <= 31'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_SIGMA:    sigma_reg  <= cfg_data;
                REG_KIND:     kind_reg   <= cfg_data[3:0];
                REG_WRAP_X:   wrap_x_reg <= cfg_data[30:0];
                REG_WRAP_Y:   wrap_y_reg <= cfg_data[30:0];
                REG_WRAP_Z:   wrap_z_reg <= cfg_data[30:0];
                REG_PERIOD_X: per_x_reg  <= cfg_data[30:0];
                REG_PERIOD_Y: per_y_reg  <= cfg_data[30:0];
                REG_PERIOD_Z: per_z_reg  <= cfg_data[30:0];
            endcase
        end
    end

    assign full  = q_full;
    assign q_wr  = push && !q_full;

    assign q_item.dx   = (AXES >= 1) ? fold(offset_x, wrap_x_reg, per_x_reg) : '0;
    assign q_item.dy   = (AXES >= 2) ? fold(offset_y, wrap_y_reg, per_y_reg) : '0;
    assign q_item.dz   = (AXES >= 3) ? fold(offset_z, wrap_z_reg, per_z_reg) : '0;
    assign q_item.val  = sample_value;
    assign q_item.last = last;

    assign cfg_back.sigma      = sigma_reg;
    assign cfg_back.deriv_kind = kind_reg;

endmodule

### rtl/gwds_fifo.sv
// ----------------------------------------------------------------------------
// gwds_fifo
// Short first-word-fall-through queue of folded items between the front and
// the back.
// ----------------------------------------------------------------------------
module gwds_fifo
    import gwds_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr,
    input  item_t wr_item,
    output logic  full,
    input  logic  rd,
    output item_t rd_item,
    output logic  empty
);

    item_t           mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr && !rd)
                count_reg <= count_reg + 1'b1;
            else if (rd && !wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign rd_item = mem[rd_ptr_reg];
    assign full    = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty   = (count_reg == '0);

endmodule

### rtl/gwds_div.sv
// ----------------------------------------------------------------------------
// gwds_div
// Restoring divider, one quotient bit per cycle: min(num * 2^fb / den, cap),
// with cap returned for a zero divisor.
// ----------------------------------------------------------------------------
module gwds_div
    import gwds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [95:0] dvd_reg;
    logic [63:0] rem_reg;
    logic [63:0] q_reg;
    logic        ovf_reg;
    logic [63:0] den_reg;
    logic [62:0] cap_reg;
    logic [62:0] quo_reg;

    logic [64:0] rem_sh;
    logic        ge;
    logic [64:0] rem_sub;

    assign rem_sh  = {rem_reg, dvd_reg[95]};
    assign ge      = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start && (cnt_reg == '0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64 + 7'(req.fb);
                dvd_reg  <= {req.num, 32'd0};
                rem_reg  <= '0;
                q_reg    <= '0;
                ovf_reg  <= 1'b0;
                den_reg  <= req.den;
                cap_reg  <= req.cap;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    if (den_reg == '0 || ovf_reg || q_reg >= {1'b0, cap_reg})
                        quo_reg <= cap_reg;
                    else
                        quo_reg <= q_reg[62:0];
                end
                else
                begin
                    rem_reg <= ge ? rem_sub[63:0] : rem_sh[63:0];
                    q_reg   <= {q_reg[62:0], ge};
                    ovf_reg <= ovf_reg | q_reg[63];
                    dvd_reg <= {dvd_reg[94:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

### rtl/gwds_back.sv
// ----------------------------------------------------------------------------
// gwds_back
// Sequencer over one shared 32x32 multiplier and the serial divider: distance,
// Gaussian weight, derivative factor, accumulation and the normalised result.
// ----------------------------------------------------------------------------
module gwds_back
    import gwds_pkg::*;
#(
    parameter int MAX_NEIGHBORS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_back_t   cfg,
    input  logic        q_empty,
    input  item_t       q_item,
    output logic        q_rd,
    output div_req_t    div_req,
    input  div_rsp_t    div_rsp,
    output logic        out_valid,
    input  logic        pop,
    output q16_t        smoothed,
    output logic [8:0]  kept_count,
    output logic        empty_flag
);

    localparam int KEEP_CAP = (MAX_NEIGHBORS < 511) ? MAX_NEIGHBORS : 511;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ0, ST_SQ1, ST_SQ2, ST_SS, ST_SUM, ST_KEEP,
        ST_DIVGO, ST_DIVW, ST_EXP, ST_EXPW, ST_FK, ST_FMUL, ST_FMULW,
        ST_PMUL, ST_PMULW, ST_WMUL, ST_WMULW, ST_FIN, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DV_T, DV_F1, DV_F2, DV_RES
    } tag_t;

    state_t      state_reg;
    tag_t        tag_reg;
    q16_t        d_reg [3];
    q16_t        val_reg;
    logic        last_reg;
    logic [63:0] prod_reg;
    logic [63:0] sq_reg [3];
    logic [63:0] s2_reg;
    logic [63:0] r_reg;
    logic [20:0] t_reg;
    logic [31:0] acc_reg;
    logic        one_reg;
    logic [4:0]  bit_reg;
    logic [16:0] w_reg;
    logic        neg_reg;
    logic        two_reg;
    logic [31:0] fmag_reg;
    logic        fneg_reg;
    logic [31:0] pmag_reg;
    logic        pneg_reg;
    logic [63:0] ws_reg;
    logic [31:0] wt_reg;
    logic [8:0]  tally_reg;
    q16_t        res_reg;
    logic [63:0] dnum_reg;
    logic [63:0] dden_reg;
    logic [5:0]  dfb_reg;
    logic [62:0] dcap_reg;
    logic        out_valid_reg;
    q16_t        smoothed_reg;
    logic [8:0]  count_reg;
    logic        flag_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [1:0]  ax_sel;
    logic [1:0]  mix_a;
    logic [1:0]  mix_b;
    logic [31:0] fsat;
    logic [63:0] sq_sel;
    logic [63:0] ws_mag;

    always_comb
    begin
        ax_sel = 2'd0;
        mix_a  = 2'd0;
        mix_b  = 2'd1;
        case (cfg.deriv_kind)
            KIND_Y, KIND_YY: ax_sel = 2'd1;
            KIND_Z, KIND_ZZ: ax_sel = 2'd2;
            KIND_XZ:         mix_b  = 2'd2;
            KIND_YZ:
            begin
                mix_a = 2'd1;
                mix_b = 2'd2;
            end
            default:         ax_sel = 2'd0;
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ0:
            begin
                mul_a = mag32(d_reg[0]);
                mul_b = mag32(d_reg[0]);
            end
            ST_SQ1:
            begin
                mul_a = mag32(d_reg[1]);
                mul_b = mag32(d_reg[1]);
            end
            ST_SQ2:
            begin
                mul_a = mag32(d_reg[2]);
                mul_b = mag32(d_reg[2]);
            end
            ST_SS:
            begin
                mul_a = cfg.sigma;
                mul_b = cfg.sigma;
            end
            ST_EXP:
            begin
                mul_a = acc_reg;
                mul_b = exp_coef(bit_reg);
            end
            ST_FMUL:
            begin
                mul_a = mag32(d_reg[mix_a]);
                mul_b = mag32(d_reg[mix_b]);
            end
            ST_PMUL:
            begin
                mul_a = fmag_reg;
                mul_b = mag32(val_reg);
            end
            ST_WMUL:
            begin
                mul_a = pmag_reg;
                mul_b = {15'd0, w_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    assign fsat   = sat_mag({1'b0, div_rsp.quo}, neg_reg);
    assign sq_sel = sq_reg[ax_sel];
    assign ws_mag = ws_reg[63] ? (64'd0 - ws_reg) : ws_reg;

    assign q_rd = (state_reg == ST_IDLE) && !q_empty;

    assign div_req.start = (state_reg == ST_DIVGO);
    assign div_req.num   = dnum_reg;
    assign div_req.den   = dden_reg;
    assign div_req.fb    = dfb_reg;
    assign div_req.cap   = dcap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            ws_reg        <= '0;
            wt_reg        <= '0;
            tally_reg     <= '0;
        end
        else
        begin
            if (state_reg == ST_OUT && (!out_valid_reg || pop))
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        d_reg[0]  <= q_item.dx;
                        d_reg[1]  <= q_item.dy;
                        d_reg[2]  <= q_item.dz;
                        val_reg   <= q_item.val;
                        last_reg  <= q_item.last;
                        state_reg <= ST_SQ0;
                    end
                end
                ST_SQ0: state_reg <= ST_SQ1;
                ST_SQ1:
                begin
                    sq_reg[0] <= prod_reg;
                    state_reg <= ST_SQ2;
                end
                ST_SQ2:
                begin
                    sq_reg[1] <= prod_reg;
                    state_reg <= ST_SS;
                end
                ST_SS:
                begin
                    sq_reg[2] <= prod_reg;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    s2_reg    <= prod_reg;
                    r_reg     <= sq_reg[0] + sq_reg[1] + sq_reg[2];
                    state_reg <= ST_KEEP;
                end
                ST_KEEP:
                begin
                    if (cfg.sigma != '0 && tally_reg < 9'(KEEP_CAP))
                    begin
                        dnum_reg  <= r_reg;
                        dden_reg  <= s2_reg;
                        dfb_reg   <= FB_T;
                        dcap_reg  <= T_CAP;
                        tag_reg   <= DV_T;
                        state_reg <= ST_DIVGO;
                    end
                    else
                        state_reg <= ST_FIN;
                end
                ST_DIVGO: state_reg <= ST_DIVW;
                ST_DIVW:
                begin
                    if (div_rsp.done)
                    begin
                        unique case (tag_reg)
                            DV_T:
                            begin
                                if (div_rsp.quo > T_LIMIT)
                                    state_reg <= ST_FIN;
                                else
                                begin
                                    t_reg     <= div_rsp.quo[20:0];
                                    one_reg   <= 1'b1;
                                    acc_reg   <= '0;
                                    bit_reg   <= '0;
                                    state_reg <= ST_EXP;
                                end
                            end
                            DV_F1:
                            begin
                                if (two_reg)
                                begin
                                    dnum_reg  <= {1'b0, div_rsp.quo};
                                    dfb_reg   <= FB_HALF;
                                    dcap_reg  <= CAP_F;
                                    tag_reg   <= DV_F2;
                                    state_reg <= ST_DIVGO;
                                end
                                else
                                begin
                                    fmag_reg  <= fsat;
                                    fneg_reg  <= neg_reg && (fsat != '0);
                                    state_reg <= ST_PMUL;
                                end
                            end
                            DV_F2:
                            begin
                                fmag_reg  <= fsat;
                                fneg_reg  <= neg_reg && (fsat != '0);
                                state_reg <= ST_PMUL;
                            end
                            DV_RES:
                            begin
                                res_reg   <= neg_reg ? (32'sd0 - $signed(fsat))
                                                     : $signed(fsat);
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_EXP: state_reg <= ST_EXPW;
                ST_EXPW:
                begin
                    if (t_reg[bit_reg])
                    begin
                        acc_reg <= one_reg ? exp_coef(bit_reg) : prod_reg[63:32];
                        one_reg <= 1'b0;
                    end
                    if (bit_reg == 5'(EXP_BITS - 1))
                        state_reg <= ST_FK;
                    else
                    begin
                        bit_reg   <= bit_reg + 1'b1;
                        state_reg <= ST_EXP;
                    end
                end
                ST_FK:
                begin
                    w_reg   <= one_reg ? 17'h1_0000 : {1'b0, acc_reg[31:16]};
                    dden_reg <= s2_reg;
                    tag_reg  <= DV_F1;
                    case (cfg.deriv_kind)
                        KIND_VALUE:
                        begin
                            fmag_reg  <= 32'd65536;
                            fneg_reg  <= 1'b0;
                            state_reg <= ST_PMUL;
                        end
                        KIND_X, KIND_Y, KIND_Z:
                        begin
                            dnum_reg  <= {32'd0, mag32(d_reg[ax_sel])};
                            neg_reg   <= d_reg[ax_sel][31];
                            dfb_reg   <= FB_FULL;
                            dcap_reg  <= CAP_F;
                            two_reg   <= 1'b0;
                            state_reg <= ST_DIVGO;
                        end
                        KIND_XX, KIND_YY, KIND_ZZ:
                        begin
                            dnum_reg  <= (sq_sel < s2_reg) ? (s2_reg - sq_sel)
                                                           : (sq_sel - s2_reg);
                            neg_reg   <= (sq_sel < s2_reg);
                            dfb_reg   <= FB_FULL;
                            dcap_reg  <= CAP_STEP;
                            two_reg   <= 1'b1;
                            state_reg <= ST_DIVGO;
                        end
                        KIND_XY, KIND_XZ, KIND_YZ: state_reg <= ST_FMUL;
                        default:
                        begin
                            fmag_reg  <= '0;
                            fneg_reg  <= 1'b0;
                            state_reg <= ST_PMUL;
                        end
                    endcase
                end
                ST_FMUL: state_reg <= ST_FMULW;
                ST_FMULW:
                begin
                    dnum_reg  <= prod_reg;
                    neg_reg   <= (d_reg[mix_a][31] != d_reg[mix_b][31])
                                 && (prod_reg != '0);
                    dfb_reg   <= FB_FULL;
                    dcap_reg  <= CAP_STEP;
                    two_reg   <= 1'b1;
                    state_reg <= ST_DIVGO;
                end
                ST_PMUL: state_reg <= ST_PMULW;
                ST_PMULW:
                begin
                    pmag_reg  <= sat_mag({16'd0, prod_reg[63:16]},
                                         fneg_reg != val_reg[31]);
                    pneg_reg  <= (fneg_reg != val_reg[31]);
                    state_reg <= ST_WMUL;
                end
                ST_WMUL: state_reg <= ST_WMULW;
                ST_WMULW:
                begin
                    ws_reg    <= pneg_reg ? (ws_reg - prod_reg) : (ws_reg + prod_reg);
                    wt_reg    <= wt_reg + 32'(w_reg);
                    tally_reg <= tally_reg + 1'b1;
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!last_reg)
                        state_reg <= ST_IDLE;
                    else if (tally_reg != '0 && wt_reg != '0)
                    begin
                        neg_reg   <= ws_reg[63];
                        dnum_reg  <= ws_mag;
                        dden_reg  <= {32'd0, wt_reg};
                        dfb_reg   <= FB_NONE;
                        dcap_reg  <= CAP_F;
                        tag_reg   <= DV_RES;
                        state_reg <= ST_DIVGO;
                    end
                    else
                    begin
                        res_reg   <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || pop)
                    begin
                        smoothed_reg  <= res_reg;
                        count_reg     <= tally_reg;
                        flag_reg      <= (tally_reg == '0);
                        ws_reg        <= '0;
                        wt_reg        <= '0;
                        tally_reg     <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign smoothed   = smoothed_reg;
    assign kept_count = count_reg;
    assign empty_flag = flag_reg;

endmodule

### rtl/gaussian_weighted_derivative_stencil_unit.sv
// ----------------------------------------------------------------------------
// gaussian_weighted_derivative_stencil_unit
// Gaussian-weighted smoothing and derivative over the neighbours of one
// centre cell, Q16.16, one result beat per run of neighbour beats.
//
//   channel  direction  handshake             payload
//   input    in         push / full           offset_x/y/z, sample_value, last
//   result   out        pop / empty           smoothed, kept_count, empty_flag
//   config   in         cfg_we                cfg_index, cfg_data
//
// An input beat is folded and queued on acceptance; the queue holds four.
// The back works on one neighbour at a time, its time set by passes through
// the serial divider: one for the value, two for a first derivative, three
// for a second or mixed one, one for a neighbour dropped on distance and
// none for one dropped for zero sigma or a full tally. The last beat adds
// the normalising divide when weight was kept; one quotient bit per cycle.
// Reset clears configuration to defaults and the accumulators; no sweep.
// A waiting result stalls the back only when the next result is ready.
// ----------------------------------------------------------------------------
module gaussian_weighted_derivative_stencil_unit
    import gwds_pkg::*;
#(
    parameter int MAX_NEIGHBORS = 256,
    parameter int AXES          = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  q16_t        offset_x,
    input  q16_t        offset_y,
    input  q16_t        offset_z,
    input  q16_t        sample_value,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output q16_t        smoothed,
    output logic [8:0]  kept_count,
    output logic        empty_flag,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic      q_full;
    logic      q_wr;
    item_t     q_wr_item;
    logic      q_rd;
    item_t     q_rd_item;
    logic      q_empty;
    cfg_back_t cfg_back;
    div_req_t  div_req;
    div_rsp_t  div_rsp;
    logic      out_valid;

    gwds_front #(
        .AXES(AXES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .offset_x(offset_x),
        .offset_y(offset_y),
        .offset_z(offset_z),
        .sample_value(sample_value),
        .last(last),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .q_full(q_full),
        .q_wr(q_wr),
        .q_item(q_wr_item),
        .cfg_back(cfg_back)
    );

    gwds_fifo u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .wr(q_wr),
        .wr_item(q_wr_item),
        .full(q_full),
        .rd(q_rd),
        .rd_item(q_rd_item),
        .empty(q_empty)
    );

    gwds_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .req(div_req),
        .rsp(div_rsp)
    );

    gwds_back #(
        .MAX_NEIGHBORS(MAX_NEIGHBORS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_back),
        .q_empty(q_empty),
        .q_item(q_rd_item),
        .q_rd(q_rd),
        .div_req(div_req),
        .div_rsp(div_rsp),
        .out_valid(out_valid),
        .pop(pop),
        .smoothed(smoothed),
        .kept_count(kept_count),
        .empty_flag(empty_flag)
    );

    assign empty = !out_valid;

endmodule

### rtl/gwds_checker.sv
// ----------------------------------------------------------------------------
// gwds_checker
// Port-level checks on result beats of the stencil unit, bound to the top.
// ----------------------------------------------------------------------------
module gwds_checker
#(
    parameter int MAX_NEIGHBORS = 256
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input logic signed [31:0] smoothed,
    input logic [8:0]        kept_count,
    input logic              empty_flag
);

    localparam int KEEP_CAP = (MAX_NEIGHBORS < 511) ? MAX_NEIGHBORS : 511;

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && empty_flag |-> smoothed == 32'sd0 && kept_count == 9'd0)
        else $error("empty result carries data");

    a_flag_count: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !empty_flag |-> kept_count != 9'd0)
        else $error("kept count zero without empty flag");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> kept_count <= 9'(KEEP_CAP))
        else $error("kept count beyond cap");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(smoothed) && $stable(kept_count))
        else $error("result beat dropped or changed while stalled");

endmodule

bind gaussian_weighted_derivative_stencil_unit gwds_checker #(
    .MAX_NEIGHBORS(MAX_NEIGHBORS)
) u_gwds_checker (
    .clk(clk),
    .rst_n(rst_n),
    .empty(empty),
    .pop(pop),
    .smoothed(smoothed),
    .kept_count(kept_count),
    .empty_flag(empty_flag)
);
